### rtl/mcht_pkg.sv
// Package for the monotone convex hull trick block.
// Holds sizes, request/status/state codes and the word types.
// No dependencies.
package mcht_pkg;

  localparam int MaxLines = 1024;
  localparam int AddrW    = $clog2(MaxLines);
  localparam int CntW     = AddrW + 1;

  typedef enum logic [1:0] {
    ReqClear = 2'd0,
    ReqAdd   = 2'd1,
    ReqQuery = 2'd2,
    ReqNone  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatEmpty = 2'd1,
    StatSlope = 2'd2,
    StatFull  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    StIdle,
    StAddQ,
    StAddP,
    StAddMul,
    StAddSum,
    StAddCmp,
    StQryCur,
    StQryNxt,
    StQryMul,
    StQryCmp,
    StQryVal,
    StQrySum,
    StResp
  } state_e;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [47:0] offset;
    logic [19:0]        label;
  } line_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] line_slope;
    logic signed [47:0] line_offset;
    logic [19:0]        line_label;
    logic signed [31:0] query_x;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] min_value;
    logic [19:0]        found_label;
    logic [1:0]         status;
  } out_word_t;

endpackage

### rtl/monotone_convex_hull_trick.sv
// Lower-envelope line store with a monotone query pointer.
// Depends on mcht_pkg and mcht_line_ram.
//
// Usage: one request word in on in_valid_i/in_ready_o, exactly one result
// word out on out_valid_o/out_ready_i. Requests are clear, add line and
// query; status flags empty queries, non-decreasing slopes and a full store.
// One request is processed at a time; a new word is taken while the last
// result still sits in the output register.
// Steps from accept to output valid (output register free):
//   clear / unknown request / empty query / add to an empty store: response
//   add: read of the last line, then per redundancy test one line store read,
//        two stages of split 49x33 cross products and one compare; then response
//   query: read of the current line; per next line to test a store read,
//        32x33 product and compare; then value product, sum and response
// Pops and advances are amortized.
// Reset empties the store (count and pointer to zero); store contents are
// not cleared. If the receiver stalls, the finished result waits in a
// holding stage and the block takes no further word until it moves on.
module monotone_convex_hull_trick import mcht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [AddrW-1:0] pos_q, pos_d;

  logic signed [31:0] a_q, a_d;
  logic signed [47:0] b_q, b_d;
  logic [19:0]        lab_q, lab_d;
  logic signed [31:0] x_q, x_d;

  line_t lq_q, lq_d;   // last line on add, current line on query
  line_t lp_q, lp_d;   // second last on add, next line on query

  logic signed [58:0] pl_hi_q, pl_hi_d, pl_lo_q, pl_lo_d;
  logic signed [58:0] pr_hi_q, pr_hi_d, pr_lo_q, pr_lo_d;
  logic signed [81:0] lhs_q, lhs_d, rhs_q, rhs_d;
  logic signed [65:0] qprod_q, qprod_d;
  logic signed [48:0] db_q, db_d;
  logic signed [63:0] vprod_q, vprod_d;

  out_word_t res_q, res_d;
  out_word_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  line_t            wr_data, rd_data;

  logic             accept;
  logic [CntW-1:0]  cnt_m1, cnt_m2, cnt_m3, pos_p1, pos_p2;
  logic             slope_bad, pop_ok, adv_ok, out_free;
  logic signed [48:0] dbq, dbr;
  logic [32:0]        daq, dap, qda;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign cnt_m1 = count_q - CntW'(1);
  assign cnt_m2 = count_q - CntW'(2);
  assign cnt_m3 = count_q - CntW'(3);
  assign pos_p1 = {1'b0, pos_q} + CntW'(1);
  assign pos_p2 = {1'b0, pos_q} + CntW'(2);

  assign slope_bad = a_q >= rd_data.slope;
  assign pop_ok    = lhs_q >= rhs_q;
  assign adv_ok    = qprod_q > $signed({{17{db_q[48]}}, db_q});

  // cross-product operands
  assign dbq = $signed({lq_q.offset[47], lq_q.offset}) - $signed({lp_q.offset[47], lp_q.offset});
  assign dbr = $signed({b_q[47], b_q}) - $signed({lq_q.offset[47], lq_q.offset});
  assign daq = {lq_q.slope[31], lq_q.slope} - {a_q[31], a_q};
  assign dap = {lp_q.slope[31], lp_q.slope} - {lq_q.slope[31], lq_q.slope};
  assign qda = {lq_q.slope[31], lq_q.slope} - {lp_q.slope[31], lp_q.slope};

  mcht_line_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (req_e'(in_word_i.req_type))
            ReqAdd:   state_d = (count_q == '0) ? StResp : StAddQ;
            ReqQuery: state_d = (count_q == '0) ? StResp : StQryCur;
            default:  state_d = StResp;
          endcase
        end
      end
      StAddQ: begin
        if (!slope_bad && count_q != CntW'(MaxLines) && count_q > CntW'(1)) begin
          state_d = StAddP;
        end else begin
          state_d = StResp;
        end
      end
      StAddP:   state_d = StAddMul;
      StAddMul: state_d = StAddSum;
      StAddSum: state_d = StAddCmp;
      StAddCmp: state_d = (pop_ok && cnt_m1 > CntW'(1)) ? StAddP : StResp;
      StQryCur: state_d = (pos_p1 < count_q) ? StQryNxt : StQryVal;
      StQryNxt: state_d = StQryMul;
      StQryMul: state_d = StQryCmp;
      StQryCmp: state_d = (adv_ok && pos_p2 < count_q) ? StQryNxt : StQryVal;
      StQryVal: state_d = StQrySum;
      StQrySum: state_d = StResp;
      StResp:   state_d = out_free ? StIdle : StResp;
      default:  state_d = StIdle;
    endcase
  end

  // datapath and store control
  always_comb begin
    count_d     = count_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    a_d         = a_q;
    b_d         = b_q;
    lab_d       = lab_q;
    x_d         = x_q;
    lq_d        = lq_q;
    lp_d        = lp_q;
    pl_hi_d     = pl_hi_q;
    pl_lo_d     = pl_lo_q;
    pr_hi_d     = pr_hi_q;
    pr_lo_d     = pr_lo_q;
    lhs_d       = lhs_q;
    rhs_d       = rhs_q;
    qprod_d     = qprod_q;
    db_d        = db_q;
    vprod_d     = vprod_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    wr_en       = 1'b0;
    wr_addr     = count_q[AddrW-1:0];
    wr_data     = '{slope: a_q, offset: b_q, label: lab_q};
    rd_en       = 1'b0;
    rd_addr     = cnt_m1[AddrW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          a_d   = in_word_i.line_slope;
          b_d   = in_word_i.line_offset;
          lab_d = in_word_i.line_label;
          x_d   = in_word_i.query_x;
          res_d = '{min_value: '0, found_label: '0, status: StatOk};
          unique case (req_e'(in_word_i.req_type))
            ReqClear: begin
              count_d = '0;
              ptr_d   = '0;
            end
            ReqAdd: begin
              if (count_q == '0) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '{slope: in_word_i.line_slope, offset: in_word_i.line_offset,
                            label: in_word_i.line_label};
                count_d = CntW'(1);
              end else begin
                rd_en   = 1'b1;
                rd_addr = cnt_m1[AddrW-1:0];
              end
            end
            ReqQuery: begin
              if (count_q == '0) begin
                res_d.status = StatEmpty;
              end else begin
                // clamp pointer to the last line
                if ({1'b0, ptr_q} > cnt_m1) begin
                  pos_d = cnt_m1[AddrW-1:0];
                end else begin
                  pos_d = ptr_q;
                end
                rd_en   = 1'b1;
                rd_addr = pos_d;
              end
            end
            default: ;
          endcase
        end
      end
      StAddQ: begin
        lq_d = rd_data;
        if (slope_bad) begin
          res_d.status = StatSlope;
        end else if (count_q == CntW'(MaxLines)) begin
          res_d.status = StatFull;
        end else if (count_q > CntW'(1)) begin
          rd_en   = 1'b1;
          rd_addr = cnt_m2[AddrW-1:0];
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CntW'(1);
        end
      end
      StAddP: begin
        lp_d = rd_data;
      end
      StAddMul: begin
        // 49-bit differences split into signed high and unsigned low halves
        pl_hi_d = $signed(dbq[48:24]) * $signed({1'b0, daq});
        pl_lo_d = $signed({1'b0, dbq[23:0]}) * $signed({1'b0, daq});
        pr_hi_d = $signed(dbr[48:24]) * $signed({1'b0, dap});
        pr_lo_d = $signed({1'b0, dbr[23:0]}) * $signed({1'b0, dap});
      end
      StAddSum: begin
        lhs_d = $signed({pl_hi_q[57:0], 24'b0}) + $signed({24'b0, pl_lo_q[57:0]});
        rhs_d = $signed({pr_hi_q[57:0], 24'b0}) + $signed({24'b0, pr_lo_q[57:0]});
      end
      StAddCmp: begin
        if (pop_ok) begin
          count_d = cnt_m1;
          lq_d    = lp_q;
          if (cnt_m1 > CntW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = cnt_m3[AddrW-1:0];
          end else begin
            wr_en   = 1'b1;
            wr_addr = cnt_m1[AddrW-1:0];
            count_d = count_q;
          end
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CntW'(1);
        end
      end
      StQryCur: begin
        lq_d = rd_data;
        if (pos_p1 < count_q) begin
          rd_en   = 1'b1;
          rd_addr = pos_p1[AddrW-1:0];
        end
      end
      StQryNxt: begin
        lp_d = rd_data;
      end
      StQryMul: begin
        qprod_d = $signed(x_q) * $signed({1'b0, qda});
        db_d    = $signed({lp_q.offset[47], lp_q.offset})
                - $signed({lq_q.offset[47], lq_q.offset});
      end
      StQryCmp: begin
        if (adv_ok) begin
          pos_d = pos_p1[AddrW-1:0];
          lq_d  = lp_q;
          if (pos_p2 < count_q) begin
            rd_en   = 1'b1;
            rd_addr = pos_p2[AddrW-1:0];
          end
        end
      end
      StQryVal: begin
        vprod_d = lq_q.slope * x_q;
      end
      StQrySum: begin
        res_d.min_value   = vprod_q + $signed({{16{lq_q.offset[47]}}, lq_q.offset});
        res_d.found_label = lq_q.label;
        res_d.status      = StatOk;
        ptr_d             = pos_q;
      end
      StResp: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    a_q     <= a_d;
    b_q     <= b_d;
    lab_q   <= lab_d;
    x_q     <= x_d;
    lq_q    <= lq_d;
    lp_q    <= lp_d;
    pl_hi_q <= pl_hi_d;
    pl_lo_q <= pl_lo_d;
    pr_hi_q <= pr_hi_d;
    pr_lo_q <= pr_lo_d;
    lhs_q   <= lhs_d;
    rhs_q   <= rhs_d;
    qprod_q <= qprod_d;
    db_q    <= db_d;
    vprod_q <= vprod_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

endmodule

### rtl/mcht_line_ram.sv
// Line store: one write port, one read port, registered read data.
// Depends on mcht_pkg.
module mcht_line_ram import mcht_pkg::*; (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  line_t            wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output line_t            rd_data_o
);

  line_t mem [MaxLines];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule
